### sv/gasp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the grid path search.
// No dependencies; imported by the controller, datapath and top level.
package gasp_pkg;

   localparam int COORD_W = 5;
   localparam int SIZE_W  = 6;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;

   localparam logic [15:0] COST_STRAIGHT = 16'd10;
   localparam logic [15:0] COST_DIAG     = 16'd14;
   localparam logic [4:0]  OUT_CNT_LAST  = 5'd31;
   localparam logic [2:0]  NB_LAST       = 3'd7;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   // configuration register indexes
   typedef enum logic {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_idx_type;

   // per-cell search mark
   typedef enum logic [1:0] {
      MARK_NONE   = 2'b00,
      MARK_OPEN   = 2'b01,
      MARK_CLOSED = 2'b10
   } mark_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic same_ld;
      logic clr;
      logic init;
      logic scan_init;
      logic scan;
      logic pick;
      logic nb_wr;
      logic nb_next;
      logic tr_step;
      logic tr_load;
      logic emit_init;
      logic emit_ld;
      logic emit_next;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic same;
      logic clr_last;
      logic scan_done;
      logic best_v;
      logic best_goal;
      logic nb_ok;
      logic nb_last;
      logic tr_at_start;
      logic out_last;
   } sts_type;

   // octile distance: 10*max + 4*min
   function automatic logic [15:0] octile(input logic [6:0] ax, input logic [6:0] ay,
                                          input logic [6:0] bx, input logic [6:0] by);
      logic [6:0] dx;
      logic [6:0] dy;
      logic [6:0] lo;
      logic [6:0] hi;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      lo = (dx < dy) ? dx : dy;
      hi = (dx < dy) ? dy : dx;
      return 16'(hi) * 16'd10 + 16'(lo) * 16'd4;
   endfunction

   // neighbour order: x-major, offsets coded 0,1,2 for -1,0,+1
   function automatic logic [1:0] nb_dx(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nb_dy(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0, 3'd3, 3'd5: r = 2'd0;
         3'd1, 3'd6:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

### sv/gasp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gasp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/gasp_ctrl.sv
`timescale 1ns / 1ps
// Search sequencer: request intake, clear, scan, expand, trace-back, emit.
// Depends on gasp_pkg; drives gasp_dpath through cmd_type/sts_type.
module gasp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output gasp_pkg::cmd_type cmd,
   input  gasp_pkg::sts_type sts
);
   import gasp_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_CHECK     = 14'b00000000000010,
      S_CLEAR     = 14'b00000000000100,
      S_INIT      = 14'b00000000001000,
      S_SCAN_INIT = 14'b00000000010000,
      S_SCAN      = 14'b00000000100000,
      S_PICK      = 14'b00000001000000,
      S_NB_RD     = 14'b00000010000000,
      S_NB_WR     = 14'b00000100000000,
      S_TR_CHK    = 14'b00001000000000,
      S_TR_WT     = 14'b00010000000000,
      S_EMIT_RD   = 14'b00100000000000,
      S_EMIT_WT   = 14'b01000000000000,
      S_OUT       = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.same) begin
               cmd.same_ld = 1'b1;
               state_in    = S_OUT;
            end else begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_SCAN_INIT;
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = S_PICK;
         end
         S_PICK: begin
            if (!sts.best_v) begin
               state_in = S_IDLE;
            end else begin
               cmd.pick = 1'b1;
               state_in = sts.best_goal ? S_TR_CHK : S_NB_RD;
            end
         end
         S_NB_RD: begin
            if (sts.nb_ok) begin
               state_in = S_NB_WR;
            end else begin
               cmd.nb_next = 1'b1;
               if (sts.nb_last) state_in = S_SCAN_INIT;
            end
         end
         S_NB_WR: begin
            cmd.nb_wr   = 1'b1;
            cmd.nb_next = 1'b1;
            state_in    = sts.nb_last ? S_SCAN_INIT : S_NB_RD;
         end
         S_TR_CHK: begin
            if (sts.tr_at_start) begin
               cmd.emit_init = 1'b1;
               state_in      = S_EMIT_RD;
            end else begin
               cmd.tr_step = 1'b1;
               state_in    = S_TR_WT;
            end
         end
         S_TR_WT: begin
            cmd.tr_load = 1'b1;
            state_in    = S_TR_CHK;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_WT;
         end
         S_EMIT_WT: begin
            cmd.emit_ld = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (sts.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/gasp_dpath.sv
`timescale 1ns / 1ps
// Search datapath: config registers, cell RAMs, open-list scan, expansion,
// trace-back and result register. Depends on gasp_pkg and gasp_ram.
module gasp_dpath #(
   parameter int GRID_W = 32,
   parameter int GRID_H = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [gasp_pkg::SIZE_W-1:0] csr_wdata,
   input  logic [gasp_pkg::REQ_W-1:0]  req_tdata,
   output logic [gasp_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  gasp_pkg::cmd_type           cmd,
   output gasp_pkg::sts_type           sts
);
   import gasp_pkg::*;

   localparam int XW  = $clog2(GRID_W);
   localparam int YW  = $clog2(GRID_H);
   localparam int AW  = XW + YW;
   localparam int NC  = 2 ** AW;
   localparam int TD  = GRID_W + GRID_H;
   localparam int TAW = $clog2(TD);

   function automatic logic [6:0] eff_size(input logic [SIZE_W-1:0] v, input logic [6:0] lim);
      logic [6:0] r;
      if (v == '0) r = 7'd1;
      else if (7'(v) > lim) r = lim;
      else r = 7'(v);
      return r;
   endfunction

   function automatic logic [6:0] sat(input logic [COORD_W-1:0] v, input logic [6:0] lim);
      return (7'(v) >= lim) ? lim - 7'd1 : 7'(v);
   endfunction

   // configuration registers
   logic [SIZE_W-1:0] cfg_w_ff, cfg_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= SIZE_RESET;
         cfg_h_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_GRID_WIDTH:  cfg_w_ff <= csr_wdata;
            REG_GRID_HEIGHT: cfg_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request latch with saturation
   logic [6:0]    w_eff, h_eff;
   logic [6:0]    w_ff, h_ff;
   logic [XW-1:0] sx_ff, gx_ff;
   logic [YW-1:0] sy_ff, gy_ff;

   assign w_eff = eff_size(cfg_w_ff, 7'(GRID_W));
   assign h_eff = eff_size(cfg_h_ff, 7'(GRID_H));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff  <= w_eff;
         h_ff  <= h_eff;
         sx_ff <= XW'(sat(req_tdata[4:0],   w_eff));
         sy_ff <= YW'(sat(req_tdata[9:5],   h_eff));
         gx_ff <= XW'(sat(req_tdata[14:10], w_eff));
         gy_ff <= YW'(sat(req_tdata[19:15], h_eff));
      end
   end

   logic [AW-1:0] s_cell, g_cell;
   assign s_cell = {sy_ff, sx_ff};
   assign g_cell = {gy_ff, gx_ff};

   // RAM ports
   logic          mk_we, g_we, h_we, p_we, q_we, t_we;
   logic [AW-1:0] mk_waddr, g_waddr, q_waddr, cell_raddr;
   logic [1:0]    mk_wdata, mk_rdata;
   logic [15:0]   g_wdata, h_wdata, g_rdata, h_rdata;
   logic [AW-1:0] q_wdata, q_rdata, p_rdata, t_rdata;
   logic [AW-1:0] q_raddr;
   logic [TAW-1:0] t_raddr;

   // scan pipeline state
   logic [AW:0]   scan_idx_ff, tail_ff;
   logic          s1_v_ff, s2_v_ff;
   logic [AW-1:0] s2_cell_ff;
   logic          best_v_ff;
   logic [AW-1:0] best_cell_ff;
   logic [16:0]   best_f_ff;
   logic [15:0]   best_h_ff, best_g_ff;
   logic          issue;
   logic [16:0]   f_cand;
   logic          take;

   assign issue   = cmd.scan && (scan_idx_ff < tail_ff);
   assign q_raddr = scan_idx_ff[AW-1:0];
   assign f_cand  = 17'(g_rdata) + 17'(h_rdata);
   assign take    = s2_v_ff && (mark_type'(mk_rdata) == MARK_OPEN) &&
                    (!best_v_ff || f_cand < best_f_ff ||
                     (f_cand == best_f_ff && h_rdata < best_h_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_cell_ff <= q_rdata;
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
         best_v_ff   <= 1'b0;
      end else begin
         if (issue) scan_idx_ff <= scan_idx_ff + 1'b1;
         if (take) begin
            best_v_ff    <= 1'b1;
            best_cell_ff <= s2_cell_ff;
            best_f_ff    <= f_cand;
            best_h_ff    <= h_rdata;
            best_g_ff    <= g_rdata;
         end
      end
   end

   // current cell and neighbour generation
   logic [AW-1:0] cur_ff;
   logic [15:0]   gcur_ff;
   logic [2:0]    k_ff;
   logic [XW-1:0] cur_x, nx;
   logic [YW-1:0] cur_y, ny;
   logic [1:0]    dxc, dyc;
   logic          ok_x, ok_y;
   logic [AW-1:0] nb_cell;
   logic [15:0]   nb_cost, nb_h;
   logic          upd, app;

   assign cur_x = cur_ff[XW-1:0];
   assign cur_y = cur_ff[AW-1:XW];
   assign dxc   = nb_dx(k_ff);
   assign dyc   = nb_dy(k_ff);

   always_comb begin
      case (dxc)
         2'd0:    begin nx = cur_x - 1'b1; ok_x = (cur_x != '0); end
         2'd2:    begin nx = cur_x + 1'b1; ok_x = (7'(cur_x) + 7'd1 < w_ff); end
         default: begin nx = cur_x;        ok_x = 1'b1; end
      endcase
      case (dyc)
         2'd0:    begin ny = cur_y - 1'b1; ok_y = (cur_y != '0); end
         2'd2:    begin ny = cur_y + 1'b1; ok_y = (7'(cur_y) + 7'd1 < h_ff); end
         default: begin ny = cur_y;        ok_y = 1'b1; end
      endcase
   end

   assign nb_cell = {ny, nx};
   assign nb_cost = gcur_ff + ((dxc != 2'd1 && dyc != 2'd1) ? COST_DIAG : COST_STRAIGHT);
   assign nb_h    = octile(7'(nx), 7'(ny), 7'(gx_ff), 7'(gy_ff));
   assign upd     = (mark_type'(mk_rdata) != MARK_CLOSED) &&
                    ((mark_type'(mk_rdata) != MARK_OPEN) || nb_cost < g_rdata);
   assign app     = upd && (mark_type'(mk_rdata) != MARK_OPEN);

   // clear counter, tail and current-cell registers
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_ff + 1'b1;

      if (cmd.init) tail_ff <= (AW+1)'(1);
      else if (cmd.nb_wr && app) tail_ff <= tail_ff + 1'b1;

      if (cmd.pick) begin
         cur_ff  <= best_cell_ff;
         gcur_ff <= best_g_ff;
         k_ff    <= '0;
      end else if (cmd.nb_next) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // RAM write and read steering
   always_comb begin
      mk_we    = 1'b0;
      mk_waddr = nb_cell;
      mk_wdata = MARK_OPEN;
      g_we     = 1'b0;
      h_we     = 1'b0;
      g_waddr  = nb_cell;
      g_wdata  = nb_cost;
      h_wdata  = nb_h;
      q_we     = 1'b0;
      q_waddr  = tail_ff[AW-1:0];
      q_wdata  = nb_cell;
      p_we     = cmd.nb_wr && upd;
      if (cmd.clr) begin
         mk_we    = 1'b1;
         mk_waddr = clr_ff;
         mk_wdata = MARK_NONE;
      end else if (cmd.init) begin
         mk_we    = 1'b1;
         mk_waddr = s_cell;
         g_we     = 1'b1;
         h_we     = 1'b1;
         g_waddr  = s_cell;
         g_wdata  = '0;
         h_wdata  = octile(7'(sx_ff), 7'(sy_ff), 7'(gx_ff), 7'(gy_ff));
         q_we     = 1'b1;
         q_waddr  = '0;
         q_wdata  = s_cell;
      end else if (cmd.pick) begin
         mk_we    = 1'b1;
         mk_waddr = best_cell_ff;
         mk_wdata = MARK_CLOSED;
      end else if (cmd.nb_wr) begin
         mk_we = upd;
         g_we  = upd;
         h_we  = upd;
         q_we  = app;
      end
   end

   assign cell_raddr = s1_v_ff ? q_rdata : nb_cell;

   gasp_ram #(.WIDTH(2), .DEPTH(NC)) u_mark (
      .clock(clock), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
      .raddr(cell_raddr), .rdata(mk_rdata));

   gasp_ram #(.WIDTH(16), .DEPTH(NC)) u_gcost (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(cell_raddr), .rdata(g_rdata));

   gasp_ram #(.WIDTH(16), .DEPTH(NC)) u_hcost (
      .clock(clock), .we(h_we), .waddr(g_waddr), .wdata(h_wdata),
      .raddr(cell_raddr), .rdata(h_rdata));

   gasp_ram #(.WIDTH(AW), .DEPTH(NC)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
      .raddr(q_raddr), .rdata(q_rdata));

   // trace-back through parent links
   logic [AW-1:0]  tr_ff;
   logic [TAW-1:0] n_ff, ek_ff;
   logic [4:0]     ecnt_ff;

   gasp_ram #(.WIDTH(AW), .DEPTH(NC)) u_parent (
      .clock(clock), .we(p_we), .waddr(nb_cell), .wdata(cur_ff),
      .raddr(tr_ff), .rdata(p_rdata));

   assign t_we    = cmd.tr_step;
   assign t_raddr = ek_ff - 1'b1;

   gasp_ram #(.WIDTH(AW), .DEPTH(TD)) u_trail (
      .clock(clock), .we(t_we), .waddr(n_ff), .wdata(tr_ff),
      .raddr(t_raddr), .rdata(t_rdata));

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         tr_ff <= best_cell_ff;
         n_ff  <= '0;
      end else begin
         if (cmd.tr_step) n_ff <= n_ff + 1'b1;
         if (cmd.tr_load) tr_ff <= p_rdata;
      end
      if (cmd.emit_init) begin
         ek_ff   <= n_ff;
         ecnt_ff <= '0;
      end else if (cmd.emit_next) begin
         ek_ff   <= ek_ff - 1'b1;
         ecnt_ff <= ecnt_ff + 1'b1;
      end
   end

   // result register
   logic [XW-1:0] ox_ff;
   logic [YW-1:0] oy_ff;
   logic          ohas_ff, olast_ff;

   always_ff @(posedge clock) begin
      if (cmd.same_ld) begin
         ox_ff    <= gx_ff;
         oy_ff    <= gy_ff;
         ohas_ff  <= 1'b0;
         olast_ff <= 1'b1;
      end else if (cmd.emit_ld) begin
         ox_ff    <= t_rdata[XW-1:0];
         oy_ff    <= t_rdata[AW-1:XW];
         ohas_ff  <= 1'b1;
         olast_ff <= (ek_ff == TAW'(1)) || (ecnt_ff == OUT_CNT_LAST);
      end
   end

   assign rsp_tdata = {6'd0, COORD_W'(oy_ff), COORD_W'(ox_ff)};
   assign rsp_tuser = ohas_ff;
   assign rsp_tlast = olast_ff;

   // status
   assign sts.same        = (s_cell == g_cell);
   assign sts.clr_last    = (clr_ff == {AW{1'b1}});
   assign sts.scan_done   = cmd.scan && !issue && !s1_v_ff && !s2_v_ff;
   assign sts.best_v      = best_v_ff;
   assign sts.best_goal   = (best_cell_ff == g_cell);
   assign sts.nb_ok       = ok_x && ok_y;
   assign sts.nb_last     = (k_ff == NB_LAST);
   assign sts.tr_at_start = (tr_ff == s_cell);
   assign sts.out_last    = olast_ff;

endmodule

### sv/grid_astar_path_search.sv
`timescale 1ns / 1ps
// Top level of the octile A* grid path search.
// Depends on gasp_pkg, gasp_ctrl, gasp_dpath (which uses gasp_ram).
//
//  channel | dir | ports                         | content
//  req     | in  | req_tvalid/tready/tdata[23:0] | one search request
//  rsp     | out | rsp_tvalid/tready/tdata/tuser/tlast | one path cell per transfer
//  csr     | in  | csr_we/addr/wdata[5:0]        | grid width, grid height
//
// Work per request: a mark clear of all 2^(clog2(GRID_W)+clog2(GRID_H)) cells per
// search (1024 at default size), then per expanded cell an open-list scan of every
// queue entry, a pick and a check of its eight neighbours, then a trace-back step per
// path cell and a trail read per result. The scan through the single queue read port dominates.
// Reset is synchronous; a request is taken only when idle. A stalled result holds.
module grid_astar_path_search #(
   parameter int GRID_W = 32,
   parameter int GRID_H = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // start_x, start_y, goal_x, goal_y, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // step_x, step_y, pad
   output logic        rsp_tuser,   // has_step
   output logic        rsp_tlast,   // is_last
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [5:0]  csr_wdata
);
   import gasp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gasp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .sts(sts));

   gasp_dpath #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_dpath (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_tdata(req_tdata),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .cmd(cmd), .sts(sts));

   // one search at a time: never taking a request while a result is shown
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while result pending");

   // an empty path is a single final result
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("empty-path result not marked last");

   // after the final transfer the block is idle again
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after last result");

   // a taken request starts work at once
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("still idle after request transfer");

endmodule
